>>> rtl/core/bpm_pkg.sv
// Package for the bracket pair matcher.
// Holds the word types, stack entry type and the token and status codes.
// No dependencies.
`default_nettype none

package bpm_pkg;

  // Field widths fixed by the interface
  localparam int CLS_W  = 2;
  localparam int KIND_W = 2;
  localparam int ST_W   = 3;
  localparam int POS_W  = 12;

  // Token classes (class 3 behaves as other)
  localparam logic [CLS_W-1:0] CLS_OTHER = 2'd0;
  localparam logic [CLS_W-1:0] CLS_OPEN  = 2'd1;
  localparam logic [CLS_W-1:0] CLS_CLOSE = 2'd2;

  // Result status codes
  localparam logic [ST_W-1:0] ST_PAIR      = 3'd0;
  localparam logic [ST_W-1:0] ST_OK        = 3'd1;
  localparam logic [ST_W-1:0] ST_UNMATCHED = 3'd2;
  localparam logic [ST_W-1:0] ST_UNCLOSED  = 3'd3;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 3'd4;
  localparam logic [ST_W-1:0] ST_TOO_LONG  = 3'd5;

  // Result queue depth; the input takes a word only with room for two results
  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    logic [CLS_W-1:0]  token_class;
    logic [KIND_W-1:0] bracket_kind;
    logic              last_token;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [POS_W-1:0] open_pos;
    logic [POS_W-1:0] close_pos;
    logic             last_result;
  } out_item_t;

  // One stack entry: opener kind and its position
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
  } entry_t;

  // Up to two results written to the result queue in one cycle, slot 0 first
  typedef struct packed {
    logic      vld0;
    logic      vld1;
    out_item_t d0;
    out_item_t d1;
  } res_pair_t;

endpackage

`default_nettype wire

>>> rtl/core/bpm_stack.sv
// Opener stack storage: single-port-write, single-port-read synchronous RAM.
// Read data is registered. Uses bpm_pkg::entry_t.
`default_nettype none

module bpm_stack #(
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire bpm_pkg::entry_t wr_data,
  input  wire logic [AW-1:0]   rd_addr,
  output bpm_pkg::entry_t      rd_data
);

  bpm_pkg::entry_t mem [DEPTH];
  bpm_pkg::entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/core/bpm_res_fifo.sv
// Result queue: takes up to two result words a cycle, hands out one while out_ready is high.
// Depends on bpm_pkg (out_item_t, res_pair_t, FIFO_DEPTH).
`default_nettype none

module bpm_res_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bpm_pkg::res_pair_t wr,
  output logic                    room2,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bpm_pkg::out_item_t      out_data
);

  localparam int PW = $clog2(bpm_pkg::FIFO_DEPTH);
  localparam int CW = $clog2(bpm_pkg::FIFO_DEPTH + 1);

  bpm_pkg::out_item_t q [bpm_pkg::FIFO_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt, wp_p1;
  logic [CW-1:0] cnt_r, cnt_nxt, n_push;
  logic          pop;

  // pointer and fill bookkeeping
  always_comb begin
    pop     = out_valid & out_ready;
    wp_p1   = wp_r + PW'(1);
    n_push  = CW'(wr.vld0) + CW'(wr.vld1);
    wp_nxt  = wp_r + PW'(n_push);
    rp_nxt  = rp_r + PW'(pop);
    cnt_nxt = cnt_r + n_push - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage; slot 1 only comes with slot 0
  always_ff @(posedge clk) begin
    if (wr.vld0) begin
      q[wp_r] <= wr.d0;
    end
    if (wr.vld1) begin
      q[wp_p1] <= wr.d1;
    end
  end

  assign out_valid = (cnt_r != '0);
  assign out_data  = q[rp_r];
  assign room2     = (cnt_r <= CW'(bpm_pkg::FIFO_DEPTH - 2));

endmodule

`default_nettype wire

>>> rtl/core/bracket_pair_matcher.sv
// Bracket pair matcher top level: token control, top-of-stack register.
// Depends on bpm_pkg, bpm_stack and bpm_res_fifo.
//
// Use: tokens arrive on the in_ channel (valid/ready), one word per token,
// with class, bracket kind and a last-token flag. Results leave on the out_
// channel: a pair word for each matched close, an error word for the first
// unmatched close, overflow or overlong sequence, and on an error-free last
// token a sequence-ok or unclosed-open word. The last result of a token has
// last_result set. After an error the rest of the sequence gives nothing.
// A result is written into the result queue when its token is taken.
// Throughput: one token per cycle while in_ready is high; the top of stack
// lives in a register and the stack RAM is read one entry below it each cycle, so a pop has the new
// top ready without a stall. A last token that also closes a pair gives two
// words, which leave one at a time on the out_ channel.
// in_ready is high while the result queue has room for two words, so a
// stalled receiver holds off new tokens once more than two words are queued.
// Reset (rst_n low at a clock edge) empties the stack, the position counter
// and the queue; stack RAM contents are not cleared and need not be.
`default_nettype none

module bracket_pair_matcher #(
  parameter int STACK_DEPTH = 64,
  parameter int MAX_TOKENS  = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire bpm_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output bpm_pkg::out_item_t       out_data
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int PW = $clog2(MAX_TOKENS + 1);

  logic [CW-1:0]      count_r, count_nxt, count_after;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic               err_r, err_nxt;
  bpm_pkg::entry_t    top_r, top_nxt, top_after, new_entry, below;
  logic [AW-1:0]      rd_addr;
  logic               accept, push, pop, err_set;
  logic               too_long, full, empty, is_open, is_close;
  logic               a_vld, b_vld;
  bpm_pkg::out_item_t res_a, res_b;
  bpm_pkg::res_pair_t wr;
  logic               room2;
  logic [bpm_pkg::POS_W-1:0] cur_pos;

  // token decode and stack decision
  always_comb begin
    accept    = in_valid & in_ready;
    is_open   = (in_data.token_class == bpm_pkg::CLS_OPEN);
    is_close  = (in_data.token_class == bpm_pkg::CLS_CLOSE);
    too_long  = (pos_r >= PW'(MAX_TOKENS));
    full      = (count_r >= CW'(STACK_DEPTH));
    empty     = (count_r == '0);
    cur_pos   = bpm_pkg::POS_W'(pos_r);
    new_entry.kind = in_data.bracket_kind;
    new_entry.pos  = cur_pos;

    push    = 1'b0;
    pop     = 1'b0;
    err_set = 1'b0;
    a_vld   = 1'b0;
    res_a   = '0;
    res_a.close_pos = cur_pos;

    if (!err_r) begin
      if (too_long) begin
        a_vld        = 1'b1;
        res_a.status = bpm_pkg::ST_TOO_LONG;
        err_set      = 1'b1;
      end else if (is_open) begin
        if (full) begin
          a_vld        = 1'b1;
          res_a.status = bpm_pkg::ST_OVERFLOW;
          err_set      = 1'b1;
        end else begin
          push = 1'b1;
        end
      end else if (is_close) begin
        a_vld = 1'b1;
        if (!empty && (top_r.kind == in_data.bracket_kind)) begin
          res_a.status   = bpm_pkg::ST_PAIR;
          res_a.open_pos = top_r.pos;
          pop            = 1'b1;
        end else begin
          res_a.status = bpm_pkg::ST_UNMATCHED;
          err_set      = 1'b1;
        end
      end
    end
  end

  // stack view after this token, for the end-of-sequence word
  always_comb begin
    if (push) begin
      count_after = count_r + CW'(1);
      top_after   = new_entry;
    end else if (pop) begin
      count_after = count_r - CW'(1);
      top_after   = below;
    end else begin
      count_after = count_r;
      top_after   = top_r;
    end

    b_vld = in_data.last_token & ~err_r & ~err_set;
    res_b = '0;
    res_b.close_pos = cur_pos;
    if (count_after == '0) begin
      res_b.status = bpm_pkg::ST_OK;
    end else begin
      res_b.status   = bpm_pkg::ST_UNCLOSED;
      res_b.open_pos = top_after.pos;
    end
  end

  // pack results into queue slots, last flag on the final one
  always_comb begin
    wr = '0;
    if (accept) begin
      if (a_vld) begin
        wr.vld0 = 1'b1;
        wr.d0   = res_a;
        wr.d0.last_result = ~b_vld;
        wr.vld1 = b_vld;
        wr.d1   = res_b;
        wr.d1.last_result = 1'b1;
      end else if (b_vld) begin
        wr.vld0 = 1'b1;
        wr.d0   = res_b;
        wr.d0.last_result = 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    count_nxt = count_r;
    pos_nxt   = pos_r;
    err_nxt   = err_r;
    top_nxt   = top_r;
    if (accept) begin
      count_nxt = count_after;
      top_nxt   = top_after;
      err_nxt   = err_r | err_set;
      if (!too_long) begin
        pos_nxt = pos_r + PW'(1);
      end
      if (in_data.last_token) begin
        count_nxt = '0;
        pos_nxt   = '0;
        err_nxt   = 1'b0;
      end
    end
    // keep the entry under the next top on the RAM output
    rd_addr = AW'(count_nxt - CW'(2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pos_r   <= '0;
      err_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      pos_r   <= pos_nxt;
      err_r   <= err_nxt;
    end
  end

  // top-of-stack payload register
  always_ff @(posedge clk) begin
    top_r <= top_nxt;
  end

  bpm_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (accept & push),
    .wr_addr (AW'(count_r)),
    .wr_data (new_entry),
    .rd_addr (rd_addr),
    .rd_data (below)
  );

  bpm_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign in_ready = room2;

endmodule

`default_nettype wire

>>> rtl/core/bpm_checker.sv
// Port-level checks for the bracket pair matcher, bound to the top level.
// Depends on bpm_pkg and bracket_pair_matcher.
`default_nettype none

module bpm_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire bpm_pkg::out_item_t out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // no result word straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // only pair words may be followed by more words of the same token
  a_end_word_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != bpm_pkg::ST_PAIR) |-> out_data.last_result)
    else $error("end or error word without last_result");

  // opener position only on pair and unclosed words
  a_open_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != bpm_pkg::ST_PAIR)
      && (out_data.status != bpm_pkg::ST_UNCLOSED) |-> (out_data.open_pos == '0))
    else $error("open_pos set on a word without an opener");

  // status within the defined codes
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status <= bpm_pkg::ST_TOO_LONG))
    else $error("undefined status code");

endmodule

bind bracket_pair_matcher bpm_checker u_bpm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

>>> dv/bracket_pair_matcher_test.sv
// Self-checking testbench for bracket_pair_matcher: directed and random token
// sequences, with a scoreboard that tracks the opener stack and nesting rules.
// Depends on bpm_pkg and the bracket_pair_matcher RTL.
`timescale 1ns / 1ps

module bracket_pair_matcher_test;

  localparam int STACK_DEPTH    = 64;
  localparam int MAX_TOKENS     = 4096;
  localparam int RESET_CYCLES   = 11;
  localparam int HOLD_CYCLES    = 250;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_TOKENS   = 25;

  // Bracket kinds; the fourth kind only pairs with itself
  localparam logic [bpm_pkg::KIND_W-1:0] KIND_ROUND  = 2'd0;
  localparam logic [bpm_pkg::KIND_W-1:0] KIND_SQUARE = 2'd1;
  localparam logic [bpm_pkg::KIND_W-1:0] KIND_CURLY  = 2'd2;
  localparam logic [bpm_pkg::KIND_W-1:0] KIND_ODD    = 2'd3;
  // Unused class code, handled as an ordinary token
  localparam logic [bpm_pkg::CLS_W-1:0]  CLS_SPARE   = 2'd3;

  // Expected-result tracker: own copy of the stack, position and error flag
  class bracket_scoreboard;
    bpm_pkg::entry_t    opener_stack[$];
    int unsigned        tok_pos;
    bit                 err_latched;
    bpm_pkg::out_item_t expected_q[$];
    int                 fail_count;

    function bpm_pkg::out_item_t make_word(logic [bpm_pkg::ST_W-1:0] st,
                                           int unsigned op, int unsigned cp);
      bpm_pkg::out_item_t w;
      w.status      = st;
      w.open_pos    = op[bpm_pkg::POS_W-1:0];
      w.close_pos   = cp[bpm_pkg::POS_W-1:0];
      w.last_result = 1'b0;
      return w;
    endfunction

    // Work out the results of one accepted token word
    function void note_token(bpm_pkg::in_item_t t);
      bpm_pkg::out_item_t fresh[$];
      bpm_pkg::entry_t    ent;
      int unsigned        pos;
      bit                 is_final;
      pos      = tok_pos;
      is_final = t.last_token;
      if (!err_latched) begin
        if (pos >= MAX_TOKENS) begin
          fresh = {fresh, make_word(bpm_pkg::ST_TOO_LONG, 0, pos)};
          err_latched = 1'b1;
        end else if (t.token_class == bpm_pkg::CLS_OPEN) begin
          if (opener_stack.size() >= STACK_DEPTH) begin
            fresh = {fresh, make_word(bpm_pkg::ST_OVERFLOW, 0, pos)};
            err_latched = 1'b1;
          end else begin
            ent.kind = t.bracket_kind;
            ent.pos  = pos[bpm_pkg::POS_W-1:0];
            opener_stack = {opener_stack, ent};
          end
        end else if (t.token_class == bpm_pkg::CLS_CLOSE) begin
          // stray or mismatched close
          if (opener_stack.size() == 0 || opener_stack[$].kind != t.bracket_kind) begin
            fresh = {fresh, make_word(bpm_pkg::ST_UNMATCHED, 0, pos)};
            err_latched = 1'b1;
          end else begin
            ent = opener_stack.pop_back();
            fresh = {fresh, make_word(bpm_pkg::ST_PAIR, ent.pos, pos)};
          end
        end
        if (is_final && !err_latched) begin
          if (opener_stack.size() == 0)
            fresh = {fresh, make_word(bpm_pkg::ST_OK, 0, pos)};
          else
            fresh = {fresh, make_word(bpm_pkg::ST_UNCLOSED, opener_stack[$].pos, pos)};
        end
      end
      if (fresh.size() > 0) fresh[fresh.size()-1].last_result = 1'b1;
      if (tok_pos < MAX_TOKENS) tok_pos++;
      if (is_final) begin
        opener_stack.delete();
        tok_pos     = 0;
        err_latched = 1'b0;
      end
      foreach (fresh[i]) expected_q = {expected_q, fresh[i]};
    endfunction

    // Compare one accepted result word with the oldest expectation
    function void check_result(bpm_pkg::out_item_t got);
      bpm_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected word: expected none, got st=%0d op=%0d cp=%0d last=%0b",
                 $time, got.status, got.open_pos, got.close_pos, got.last_result);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.open_pos !== want.open_pos ||
          got.close_pos !== want.close_pos || got.last_result !== want.last_result) begin
        fail_count++;
        $display("%0t: mismatch: expected st=%0d op=%0d cp=%0d last=%0b,",
                 $time, want.status, want.open_pos, want.close_pos, want.last_result,
                 " got st=%0d op=%0d cp=%0d last=%0b",
                 got.status, got.open_pos, got.close_pos, got.last_result);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n    = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  bpm_pkg::in_item_t  in_data  = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  bpm_pkg::out_item_t out_data;

  bracket_scoreboard sb = new();

  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_req    = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int quiet       = 0;
  int tokens_sent = 0;

  bracket_pair_matcher #(
    .STACK_DEPTH(STACK_DEPTH),
    .MAX_TOKENS (MAX_TOKENS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Handshake monitor and watchdog
  always @(posedge clk) begin : monitor
    bit took;
    took = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready === 1'b1) begin
        sb.note_token(in_data);
        took = 1'b1;
      end
      if (out_valid === 1'b1 && out_ready) begin
        sb.check_result(out_data);
        took = 1'b1;
      end
      quiet = took ? 0 : quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Offer one token word and hold it until taken
  task automatic send_token(logic [bpm_pkg::CLS_W-1:0] cls,
                            logic [bpm_pkg::KIND_W-1:0] kind, bit fin);
    bpm_pkg::in_item_t w;
    w.token_class  = cls;
    w.bracket_kind = kind;
    w.last_token   = fin;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    tokens_sent++;
  endtask

  // Mostly nested sequence with random kinds and filler; sometimes left unclosed
  task automatic send_nested(int max_depth, int steps, int open_pct);
    logic [bpm_pkg::KIND_W-1:0] kinds[$];
    bpm_pkg::in_item_t          seq[$];
    bpm_pkg::in_item_t          w;
    int                         roll;
    for (int i = 0; i < steps; i++) begin
      roll = $urandom_range(99);
      w.last_token = 1'b0;
      if (roll < 15) begin
        w.token_class  = ($urandom_range(3) == 0) ? CLS_SPARE : bpm_pkg::CLS_OTHER;
        w.bracket_kind = 2'($urandom_range(3));
      end else if (kinds.size() > 0 && (kinds.size() >= max_depth || roll >= open_pct)) begin
        w.token_class  = bpm_pkg::CLS_CLOSE;
        w.bracket_kind = kinds.pop_back();
      end else begin
        w.token_class  = bpm_pkg::CLS_OPEN;
        w.bracket_kind = 2'($urandom_range(3));
        kinds = {kinds, w.bracket_kind};
      end
      seq = {seq, w};
    end
    if ($urandom_range(9) != 0) begin
      while (kinds.size() > 0) begin
        w.token_class  = bpm_pkg::CLS_CLOSE;
        w.bracket_kind = kinds.pop_back();
        seq = {seq, w};
      end
    end
    if (seq.size() == 0) begin
      w.token_class  = bpm_pkg::CLS_OTHER;
      w.bracket_kind = KIND_ROUND;
      seq = {seq, w};
    end
    seq[seq.size()-1].last_token = 1'b1;
    foreach (seq[i]) send_token(seq[i].token_class, seq[i].bracket_kind, seq[i].last_token);
  endtask

  // Unstructured tokens; usually breaks early on a stray close
  task automatic send_noise(int steps);
    for (int i = 0; i < steps; i++)
      send_token(2'($urandom_range(3)), 2'($urandom_range(3)), i == steps - 1);
  endtask

  // Fill the stack to the brim, then either unwind or push one more
  task automatic send_full_stack(bit spill);
    logic [bpm_pkg::KIND_W-1:0] kinds[$];
    logic [bpm_pkg::KIND_W-1:0] k;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      k = 2'($urandom_range(3));
      kinds = {kinds, k};
      send_token(bpm_pkg::CLS_OPEN, k, 1'b0);
    end
    if (spill) begin
      // overflow, then the close that ends the sequence stays silent
      send_token(bpm_pkg::CLS_OPEN, KIND_CURLY, 1'b0);
      send_token(bpm_pkg::CLS_CLOSE, kinds.pop_back(), 1'b1);
    end else begin
      while (kinds.size() > 1) send_token(bpm_pkg::CLS_CLOSE, kinds.pop_back(), 1'b0);
      send_token(bpm_pkg::CLS_CLOSE, kinds.pop_back(), 1'b1);
    end
  endtask

  // Stop offering and let every expected word come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_phase(int idle, int stall, bit squeeze);
    int start;
    int roll;
    idle_pct  = idle;
    stall_pct = stall;
    // long receiver hold-off while tokens keep coming
    if (squeeze) begin
      hold_req++;
      send_nested(8, 60, 57);
    end
    start = tokens_sent;
    while (tokens_sent - start < PHASE_TOKENS) begin
      roll = $urandom_range(99);
      if (roll < 80)
        send_nested($urandom_range(1, 6), $urandom_range(1, 14), 57);
      else
        send_noise($urandom_range(1, 10));
    end
    drain_results();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lone filler token as a whole sequence
    send_token(bpm_pkg::CLS_OTHER, KIND_ROUND, 1'b1);
    // pair closed on the last token: two words
    send_token(bpm_pkg::CLS_OPEN, KIND_ROUND, 1'b0);
    send_token(bpm_pkg::CLS_CLOSE, KIND_ROUND, 1'b1);
    // all kinds nested, spare class in between
    send_token(bpm_pkg::CLS_OPEN, KIND_SQUARE, 1'b0);
    send_token(bpm_pkg::CLS_OPEN, KIND_CURLY, 1'b0);
    send_token(bpm_pkg::CLS_OPEN, KIND_ODD, 1'b0);
    send_token(bpm_pkg::CLS_CLOSE, KIND_ODD, 1'b0);
    send_token(bpm_pkg::CLS_CLOSE, KIND_CURLY, 1'b0);
    send_token(CLS_SPARE, KIND_ODD, 1'b0);
    send_token(bpm_pkg::CLS_CLOSE, KIND_SQUARE, 1'b0);
    send_token(bpm_pkg::CLS_OTHER, KIND_CURLY, 1'b1);
    // stray close, then the rest of the sequence is silent
    send_token(bpm_pkg::CLS_CLOSE, KIND_SQUARE, 1'b0);
    send_token(bpm_pkg::CLS_OPEN, KIND_ROUND, 1'b0);
    send_token(bpm_pkg::CLS_CLOSE, KIND_ROUND, 1'b1);
    // wrong kind of close
    send_token(bpm_pkg::CLS_OPEN, KIND_ROUND, 1'b0);
    send_token(bpm_pkg::CLS_CLOSE, KIND_CURLY, 1'b0);
    send_token(bpm_pkg::CLS_CLOSE, KIND_ROUND, 1'b1);
    // left open at the end
    send_token(bpm_pkg::CLS_OPEN, KIND_CURLY, 1'b0);
    send_token(bpm_pkg::CLS_OTHER, KIND_SQUARE, 1'b1);
    // opener as the last token
    send_token(bpm_pkg::CLS_OPEN, KIND_ODD, 1'b1);
    // stray close as the last token
    send_token(bpm_pkg::CLS_CLOSE, KIND_ROUND, 1'b1);
    // mismatched close as the last token
    send_token(bpm_pkg::CLS_OPEN, KIND_ROUND, 1'b0);
    send_token(bpm_pkg::CLS_CLOSE, KIND_SQUARE, 1'b1);
    drain_results();

    // full stack and overflow
    send_full_stack(1'b0);
    send_full_stack(1'b1);
    send_nested(3, 8, 57);
    drain_results();

    run_phase(0, 0, 1'b1);
    run_phase(74, 0, 1'b0);
    run_phase(0, 74, 1'b0);
    run_phase(24, 24, 1'b0);

    idle_pct  = 0;
    stall_pct = 0;
    drain_results();
    repeat (10) @(posedge clk);
    if (sb.fail_count == 0 && sb.expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/bpm_pkg.sv
rtl/core/bpm_stack.sv
rtl/core/bpm_res_fifo.sv
rtl/core/bracket_pair_matcher.sv
rtl/core/bpm_checker.sv
dv/bracket_pair_matcher_test.sv
